[rtl/rdi_pkg.sv]
// ----------------------------------------------------------------------------
// rdi_pkg: shared types and constants for the ray/disk intersection core
// Payload structs, configuration struct, queue entry and fixed-point limits.
// ----------------------------------------------------------------------------
package rdi_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int RAD_W   = 31;
    localparam int NUM_W   = 67;   // sum of three 33x32 products
    localparam int DEN_W   = 66;   // sum of three 32x32 products
    localparam int DIV_W   = 97;   // remainder / shifted divisor width
    localparam int QBITS   = 31;   // quotient bits below the saturation point
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;
    localparam int IDX_W   = 3;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] EPS_RAW  =
        WORD_W'((64'd1 << FRAC_W) / 64'd100000);

    // register indexes
    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_NORMAL_Z = 3'd5;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd6;

    typedef struct packed {
        logic signed [WORD_W-1:0] origin_x;
        logic signed [WORD_W-1:0] origin_y;
        logic signed [WORD_W-1:0] origin_z;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic                     hit;
        logic                     in_front;
        logic signed [WORD_W-1:0] distance_t;
        logic signed [WORD_W-1:0] point_x;
        logic signed [WORD_W-1:0] point_y;
        logic signed [WORD_W-1:0] point_z;
    } result_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] center_x;
        logic signed [WORD_W-1:0] center_y;
        logic signed [WORD_W-1:0] center_z;
        logic signed [WORD_W-1:0] normal_x;
        logic signed [WORD_W-1:0] normal_y;
        logic signed [WORD_W-1:0] normal_z;
        logic [RAD_W-1:0]         disk_radius;
    } cfg_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
        ray_t                    ray;
    } q_entry_t;

    typedef struct packed {
        ray_t ray;
        logic neg;
        logic ovf;
        logic par;
    } div_side_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

[rtl/rdi_front.sv]
// ----------------------------------------------------------------------------
// rdi_front: ray capture and plane dot products
// Registers the ray, forms center-origin, multiplies by the normal and sums
// numerator and denominator for the queue.
// ----------------------------------------------------------------------------
module rdi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rdi_pkg::ray_t     in_data,
    input  rdi_pkg::cfg_t     cfg,
    output logic              out_valid,
    output rdi_pkg::q_entry_t out_data
);
    import rdi_pkg::*;

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    ray_t s1_ray_reg, s2_ray_reg, s3_ray_reg;
    logic signed [WORD_W:0]     s2_dx_reg, s2_dy_reg, s2_dz_reg;
    logic signed [2*WORD_W:0]   s3_nx_reg, s3_ny_reg, s3_nz_reg;
    logic signed [2*WORD_W-1:0] s3_ex_reg, s3_ey_reg, s3_ez_reg;
    q_entry_t s4_reg;

    // advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // datapath: capture, difference, products, sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ray_reg <= in_data;

            s2_ray_reg <= s1_ray_reg;
            s2_dx_reg  <= (WORD_W+1)'(cfg.center_x) - (WORD_W+1)'(s1_ray_reg.origin_x);
            s2_dy_reg  <= (WORD_W+1)'(cfg.center_y) - (WORD_W+1)'(s1_ray_reg.origin_y);
            s2_dz_reg  <= (WORD_W+1)'(cfg.center_z) - (WORD_W+1)'(s1_ray_reg.origin_z);

            s3_ray_reg <= s2_ray_reg;
            s3_nx_reg  <= s2_dx_reg * cfg.normal_x;
            s3_ny_reg  <= s2_dy_reg * cfg.normal_y;
            s3_nz_reg  <= s2_dz_reg * cfg.normal_z;
            s3_ex_reg  <= s2_ray_reg.dir_x * cfg.normal_x;
            s3_ey_reg  <= s2_ray_reg.dir_y * cfg.normal_y;
            s3_ez_reg  <= s2_ray_reg.dir_z * cfg.normal_z;

            s4_reg.ray <= s3_ray_reg;
            s4_reg.num <= NUM_W'(s3_nx_reg) + NUM_W'(s3_ny_reg) + NUM_W'(s3_nz_reg);
            s4_reg.den <= DEN_W'(s3_ex_reg) + DEN_W'(s3_ey_reg) + DEN_W'(s3_ez_reg);
        end
    end

    assign out_valid = s4_v_reg;
    assign out_data  = s4_reg;

endmodule

[rtl/rdi_queue.sv]
// ----------------------------------------------------------------------------
// rdi_queue: short FIFO between the front and back pipelines
// Register-based, one write and one read port, count-based full/empty.
// ----------------------------------------------------------------------------
module rdi_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rdi_pkg::q_entry_t  push_data,
    input  logic               pop,
    output rdi_pkg::q_entry_t  pop_data,
    output rdi_pkg::q_status_t status
);
    import rdi_pkg::*;

    q_entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]     wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;

    // track occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // store entry
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    assign pop_data         = mem_reg[rptr_reg];
    assign status.full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign status.not_empty = (cnt_reg != '0);

endmodule

[rtl/rdi_back.sv]
// ----------------------------------------------------------------------------
// rdi_back: divide, point and radius test
// Pipelined restoring divider (one quotient bit per stage), then the hit
// point, the squared distance and the saturated result register.
// ----------------------------------------------------------------------------
module rdi_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rdi_pkg::q_entry_t in_data,
    output logic              pop,
    input  rdi_pkg::cfg_t     cfg,
    output logic              out_valid,
    input  logic              out_stall,
    output rdi_pkg::result_t  out_data
);
    import rdi_pkg::*;

    logic en;

    // stage registers
    logic      b0_v_reg, b1_v_reg;
    q_entry_t  b0_reg;
    div_side_t b1_side_reg;
    logic [DIV_W-1:0] b1_n_reg, b1_d_reg;

    logic             dv_reg   [QBITS+1];
    logic [DIV_W-1:0] dr_reg   [QBITS+1];
    logic [DIV_W-1:0] dd_reg   [QBITS+1];
    logic [QBITS-1:0] dq_reg   [QBITS+1];
    div_side_t        dside_reg[QBITS+1];

    logic                     bt_v_reg, bt_inf_reg;
    logic signed [WORD_W-1:0] bt_t_reg;
    ray_t                     bt_ray_reg;

    logic                       bm_v_reg, bm_inf_reg;
    logic signed [WORD_W-1:0]   bm_t_reg;
    ray_t                       bm_ray_reg;
    logic signed [2*WORD_W-1:0] bm_mx_reg, bm_my_reg, bm_mz_reg;

    logic                     bp_v_reg, bp_inf_reg;
    logic signed [WORD_W-1:0] bp_t_reg;
    logic signed [49:0]       bp_px_reg, bp_py_reg, bp_pz_reg;

    logic                     bv_v_reg, bv_inf_reg, bv_big_reg;
    logic signed [WORD_W-1:0] bv_t_reg, bv_sx_reg, bv_sy_reg, bv_sz_reg;
    logic [RAD_W-1:0]         bv_ax_reg, bv_ay_reg, bv_az_reg;

    logic                     bs_v_reg, bs_inf_reg, bs_big_reg;
    logic signed [WORD_W-1:0] bs_t_reg, bs_sx_reg, bs_sy_reg, bs_sz_reg;
    logic [2*RAD_W-1:0]       bs_qx_reg, bs_qy_reg, bs_qz_reg, bs_r2_reg;

    logic    out_v_reg;
    result_t out_reg;

    // combinational helpers
    logic [NUM_W-1:0]         nmag;
    logic [DEN_W-1:0]         dmag;
    logic [WORD_W-1:0]        tpos;
    logic signed [WORD_W-1:0] t_next;
    logic signed [50:0]       vx, vy, vz;
    logic [50:0]              ax, ay, az;
    logic                     big_next;
    logic [63:0]              dist_sq;

    assign en  = !(out_v_reg && out_stall);
    assign pop = in_valid && en;

    assign nmag = b0_reg.num[NUM_W-1] ? NUM_W'(-b0_reg.num) : NUM_W'(b0_reg.num);
    assign dmag = b0_reg.den[DEN_W-1] ? DEN_W'(-b0_reg.den) : DEN_W'(b0_reg.den);

    // saturate quotient into t
    always_comb
    begin
        tpos = {1'b0, dq_reg[QBITS]};
        if (dside_reg[QBITS].ovf)
            t_next = dside_reg[QBITS].neg ? WORD_MIN : WORD_MAX;
        else if (dside_reg[QBITS].neg)
            t_next = -$signed(tpos);
        else
            t_next = $signed(tpos);
    end

    // offset from center and its magnitude
    always_comb
    begin
        vx = 51'(bp_px_reg) - 51'(cfg.center_x);
        vy = 51'(bp_py_reg) - 51'(cfg.center_y);
        vz = 51'(bp_pz_reg) - 51'(cfg.center_z);
        ax = vx[50] ? 51'(-vx) : 51'(vx);
        ay = vy[50] ? 51'(-vy) : 51'(vy);
        az = vz[50] ? 51'(-vz) : 51'(vz);
        big_next = (ax[50:RAD_W] != '0) || (ay[50:RAD_W] != '0) ||
                   (az[50:RAD_W] != '0);
    end

    assign dist_sq = 64'(bs_qx_reg) + 64'(bs_qy_reg) + 64'(bs_qz_reg);

    function automatic logic signed [WORD_W-1:0] sat50(input logic signed [49:0] v);
        if (v > 50'(WORD_MAX))
            return WORD_MAX;
        else if (v < 50'(WORD_MIN))
            return WORD_MIN;
        else
            return v[WORD_W-1:0];
    endfunction

    // advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_v_reg  <= 1'b0;
            b1_v_reg  <= 1'b0;
            for (int j = 0; j <= QBITS; j++)
                dv_reg[j] <= 1'b0;
            bt_v_reg  <= 1'b0;
            bm_v_reg  <= 1'b0;
            bp_v_reg  <= 1'b0;
            bv_v_reg  <= 1'b0;
            bs_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_v_reg  <= in_valid;
            b1_v_reg  <= b0_v_reg;
            dv_reg[0] <= b1_v_reg;
            for (int j = 0; j < QBITS; j++)
                dv_reg[j+1] <= dv_reg[j];
            bt_v_reg  <= dv_reg[QBITS];
            bm_v_reg  <= bt_v_reg;
            bp_v_reg  <= bm_v_reg;
            bv_v_reg  <= bp_v_reg;
            bs_v_reg  <= bv_v_reg;
            out_v_reg <= bs_v_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // take entry
            b0_reg <= in_data;

            // magnitudes and sign
            b1_side_reg.ray <= b0_reg.ray;
            b1_side_reg.neg <= b0_reg.num[NUM_W-1] ^ b0_reg.den[DEN_W-1];
            b1_side_reg.par <= (b0_reg.den == '0);
            b1_side_reg.ovf <= 1'b0;
            b1_n_reg <= {14'b0, nmag, {FRAC_W{1'b0}}};
            b1_d_reg <= {31'b0, dmag};

            // quotient overflow check
            dside_reg[0] <= '{ray: b1_side_reg.ray, neg: b1_side_reg.neg,
                              ovf: (b1_n_reg >= (b1_d_reg << QBITS)),
                              par: b1_side_reg.par};
            dr_reg[0] <= b1_n_reg;
            dd_reg[0] <= b1_d_reg;
            dq_reg[0] <= '0;

            // one quotient bit per stage
            for (int j = 0; j < QBITS; j++)
            begin
                if (dr_reg[j] >= (dd_reg[j] << (QBITS-1-j)))
                begin
                    dr_reg[j+1] <= dr_reg[j] - (dd_reg[j] << (QBITS-1-j));
                    dq_reg[j+1] <= {dq_reg[j][QBITS-2:0], 1'b1};
                end
                else
                begin
                    dr_reg[j+1] <= dr_reg[j];
                    dq_reg[j+1] <= {dq_reg[j][QBITS-2:0], 1'b0};
                end
                dd_reg[j+1]    <= dd_reg[j];
                dside_reg[j+1] <= dside_reg[j];
            end

            // saturate t, classify
            bt_t_reg   <= t_next;
            bt_inf_reg <= !dside_reg[QBITS].par && (t_next > EPS_RAW);
            bt_ray_reg <= dside_reg[QBITS].ray;

            // t times direction
            bm_t_reg   <= bt_t_reg;
            bm_inf_reg <= bt_inf_reg;
            bm_ray_reg <= bt_ray_reg;
            bm_mx_reg  <= bt_t_reg * bt_ray_reg.dir_x;
            bm_my_reg  <= bt_t_reg * bt_ray_reg.dir_y;
            bm_mz_reg  <= bt_t_reg * bt_ray_reg.dir_z;

            // point = origin + floor(t*dir)
            bp_t_reg   <= bm_t_reg;
            bp_inf_reg <= bm_inf_reg;
            bp_px_reg  <= 50'(bm_ray_reg.origin_x) + 50'(bm_mx_reg >>> FRAC_W);
            bp_py_reg  <= 50'(bm_ray_reg.origin_y) + 50'(bm_my_reg >>> FRAC_W);
            bp_pz_reg  <= 50'(bm_ray_reg.origin_z) + 50'(bm_mz_reg >>> FRAC_W);

            // offset magnitudes, saturated point
            bv_t_reg   <= bp_t_reg;
            bv_inf_reg <= bp_inf_reg;
            bv_big_reg <= big_next;
            bv_ax_reg  <= ax[RAD_W-1:0];
            bv_ay_reg  <= ay[RAD_W-1:0];
            bv_az_reg  <= az[RAD_W-1:0];
            bv_sx_reg  <= sat50(bp_px_reg);
            bv_sy_reg  <= sat50(bp_py_reg);
            bv_sz_reg  <= sat50(bp_pz_reg);

            // squares
            bs_t_reg   <= bv_t_reg;
            bs_inf_reg <= bv_inf_reg;
            bs_big_reg <= bv_big_reg;
            bs_sx_reg  <= bv_sx_reg;
            bs_sy_reg  <= bv_sy_reg;
            bs_sz_reg  <= bv_sz_reg;
            bs_qx_reg  <= bv_ax_reg * bv_ax_reg;
            bs_qy_reg  <= bv_ay_reg * bv_ay_reg;
            bs_qz_reg  <= bv_az_reg * bv_az_reg;
            bs_r2_reg  <= cfg.disk_radius * cfg.disk_radius;

            // result register; zero the fields on a miss behind the ray
            out_reg.in_front   <= bs_inf_reg;
            out_reg.hit        <= bs_inf_reg && !bs_big_reg && (dist_sq < 64'(bs_r2_reg));
            out_reg.distance_t <= bs_inf_reg ? bs_t_reg  : '0;
            out_reg.point_x    <= bs_inf_reg ? bs_sx_reg : '0;
            out_reg.point_y    <= bs_inf_reg ? bs_sy_reg : '0;
            out_reg.point_z    <= bs_inf_reg ? bs_sz_reg : '0;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

[rtl/ray_disk_intersect_core.sv]
// ----------------------------------------------------------------------------
// ray_disk_intersect_core: ray against disk intersection, Q16.16
// Front pipeline forms the plane dot products, a short queue decouples it
// from the divider / point / radius back pipeline.
// ----------------------------------------------------------------------------
//  channel | signals                        | payload
//  --------+--------------------------------+-----------------------
//  ray     | ray_valid, ray_stall, ray_data | origin, direction
//  result  | res_valid, res_stall, res_data | hit, in_front, t, point
//  config  | cfg_we, cfg_index, cfg_data    | 7 registers, write only
//
//  One ray per cycle sustained while neither stall holds the flow; stages:
//  4 front stages, queue, 3 setup stages, 31 divider stages, 6 point/test stages.
//  The divider is built from 31 one-bit stages.
//  Reset clears all valids and loads the register defaults.
//  res_stall freezes the back pipeline while a result is waiting; ray_stall
//  rises only with the queue full and the front's last stage occupied.
// ----------------------------------------------------------------------------
module ray_disk_intersect_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         ray_valid,
    output logic                         ray_stall,
    input  rdi_pkg::ray_t                ray_data,
    output logic                         res_valid,
    input  logic                         res_stall,
    output rdi_pkg::result_t             res_data,
    input  logic                         cfg_we,
    input  logic [rdi_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rdi_pkg::WORD_W-1:0]   cfg_data
);
    import rdi_pkg::*;

    cfg_t      cfg_reg;
    logic      front_en, f_valid, q_push, q_pop;
    q_entry_t  f_data, q_data;
    q_status_t q_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
            cfg_reg.center_z    <= '0;
            cfg_reg.normal_x    <= '0;
            cfg_reg.normal_y    <= '0;
            cfg_reg.normal_z    <= 32'sd65536;
            cfg_reg.disk_radius <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: cfg_reg.center_x    <= cfg_data;
                REG_CENTER_Y: cfg_reg.center_y    <= cfg_data;
                REG_CENTER_Z: cfg_reg.center_z    <= cfg_data;
                REG_NORMAL_X: cfg_reg.normal_x    <= cfg_data;
                REG_NORMAL_Y: cfg_reg.normal_y    <= cfg_data;
                REG_NORMAL_Z: cfg_reg.normal_z    <= cfg_data;
                REG_RADIUS:   cfg_reg.disk_radius <= cfg_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // hold the front when its last entry cannot enter the queue
    assign front_en  = !(f_valid && q_stat.full);
    assign ray_stall = !front_en;
    assign q_push    = f_valid && front_en;

    rdi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_en),
        .in_valid  (ray_valid),
        .in_data   (ray_data),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    rdi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (f_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_stat)
    );

    rdi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_stat.not_empty),
        .in_data   (q_data),
        .pop       (q_pop),
        .cfg       (cfg_reg),
        .out_valid (res_valid),
        .out_stall (res_stall),
        .out_data  (res_data)
    );

    // checks
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        ray_stall |-> q_stat.full)
        else $error("ray stalled with room in the queue");

    a_hit_in_front: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.hit) |-> res_data.in_front)
        else $error("hit without in_front");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.in_front) |->
            (res_data.distance_t == '0 && res_data.point_x == '0 &&
             res_data.point_y == '0 && res_data.point_z == '0))
        else $error("fields not cleared on a ray not in front");

    a_t_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.in_front) |-> (res_data.distance_t > EPS_RAW))
        else $error("in_front with t at or below epsilon");

endmodule
